@@ rtl/itpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itpt_pkg: shared types and constants for integer-to-padded-text
// Field widths, ASCII codes, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package itpt_pkg;

    localparam int VALUE_W   = 32;
    localparam int RADIX_W   = 5;
    localparam int MINW_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;

    // Dividend bits retired per division cycle
    localparam int STEP_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [DIGIT_W-1:0] DEC_TEN   = 4'd10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               negative;
        logic [MINW_W-1:0]  min_width;
        logic               left_align;
        logic               zero_pad;
        logic               upper_case;
    } in_item_t;

    typedef struct packed {
        logic load;      // capture a new transaction
        logic div_step;  // run one division chunk
        logic prep;      // size the padding and the run
        logic emit;      // stream characters
    } cmd_t;

    typedef struct packed {
        logic digit_done;  // current division finishes this cycle
        logic quo_zero;    // quotient after this cycle is zero
        logic final_char;  // last character enters the output register
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic up);
        logic [CHAR_W-1:0] base;
        base = up ? CH_UPPER_A : CH_LOWER_A;
        if (d < DEC_TEN)
            digit_char = CH_ZERO + CHAR_W'(d);
        else
            digit_char = base + CHAR_W'(d - DEC_TEN);
    endfunction

endpackage
`default_nettype wire

@@ rtl/itpt_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itpt_if: handshake channels for integer-to-padded-text
// Input item channel and output character channel, valid/ready.
// ----------------------------------------------------------------------------
interface itpt_in_if;
    logic                          valid;
    logic                          ready;
    logic [itpt_pkg::VALUE_W-1:0]  value;
    logic [itpt_pkg::RADIX_W-1:0]  radix;
    logic                          negative;
    logic [itpt_pkg::MINW_W-1:0]   min_width;
    logic                          left_align;
    logic                          zero_pad;
    logic                          upper_case;

    modport source (output valid, value, radix, negative, min_width, left_align,
                    zero_pad, upper_case, input ready);
    modport sink   (input valid, value, radix, negative, min_width, left_align,
                    zero_pad, upper_case, output ready);
endinterface

interface itpt_out_if;
    logic                          valid;
    logic                          ready;
    logic [itpt_pkg::CHAR_W-1:0]   out_char;
    logic                          last;

    modport source (output valid, out_char, last, input ready);
    modport sink   (input valid, out_char, last, output ready);
endinterface
`default_nettype wire

@@ rtl/itpt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itpt_ctrl: sequencer for integer-to-padded-text
// Steps through capture, digit extraction, run sizing and character output.
// ----------------------------------------------------------------------------
module itpt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire itpt_pkg::status_t st,
    output itpt_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_PREP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.digit_done && st.quo_zero)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (st.final_char)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

@@ rtl/itpt_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itpt_dp: datapath for integer-to-padded-text
// Chunked radix divider, digit stack, pad counters and output register.
// ----------------------------------------------------------------------------
module itpt_dp #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire itpt_pkg::cmd_t                cmd,
    output itpt_pkg::status_t                  st,
    input  wire itpt_pkg::in_item_t            item,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [itpt_pkg::CHAR_W-1:0]        out_char,
    output logic                               out_last
);

    localparam int STEP   = itpt_pkg::STEP_BITS;
    localparam int DGW    = itpt_pkg::DIGIT_W;
    localparam int NCHUNK = (VALUE_BITS + STEP - 1) / STEP;
    localparam int QW     = NCHUNK * STEP;
    localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IN_BITS = (VALUE_BITS < itpt_pkg::VALUE_W) ? VALUE_BITS
                                                              : itpt_pkg::VALUE_W;
    localparam int DEPTH  = VALUE_BITS;
    localparam int DW     = $clog2(DEPTH + 1);
    localparam int RUN_MAX = (MAX_WIDTH > VALUE_BITS + 1) ? MAX_WIDTH : VALUE_BITS + 1;
    localparam int CW     = $clog2(RUN_MAX + 1);
    localparam int PW     = $clog2(MAX_WIDTH + 1);

    typedef enum logic [1:0] {
        K_SIGN,
        K_PAD,
        K_DIG
    } kind_t;

    // transaction settings
    logic [itpt_pkg::RADIX_W-1:0] radix_reg;
    logic [CW-1:0]                wid_reg;
    logic                         left_reg;
    logic                         zpad_reg;
    logic                         up_reg;
    logic                         sign_reg;

    // divider
    logic [QW-1:0]   quo_reg;
    logic [QW-1:0]   quo_next;
    logic [DGW-1:0]  rem_reg;
    logic [DGW-1:0]  rem_next;
    logic [CHW-1:0]  chunk_reg;
    logic [STEP-1:0] qbits;
    logic [DGW:0]    part;

    // digit stack, most significant digit at entry zero
    logic [DGW-1:0] dig_reg [DEPTH];
    logic [DW-1:0]  ndig_reg;

    // emission counters
    logic [PW-1:0] pad_reg;
    logic [CW-1:0] run_reg;
    logic [CW-1:0] len;
    logic [CW-1:0] pad_full;

    logic                        out_valid_reg;
    logic [itpt_pkg::CHAR_W-1:0] out_char_reg;
    logic                        out_last_reg;

    logic                        push;
    logic                        out_load;
    kind_t                       kind;
    logic [itpt_pkg::CHAR_W-1:0] char_next;

    // one chunk of restoring division, most significant bit first
    always_comb
    begin
        rem_next = rem_reg;
        qbits    = '0;
        part     = '0;
        for (int j = 0; j < STEP; j++)
        begin
            part = {rem_next, quo_reg[QW-1-j]};
            if (part >= radix_reg)
            begin
                part           = part - radix_reg;
                qbits[STEP-1-j] = 1'b1;
            end
            rem_next = part[DGW-1:0];
        end
    end

    generate
        if (NCHUNK > 1)
        begin : g_multi
            assign quo_next = {quo_reg[QW-STEP-1:0], qbits};
        end
        else
        begin : g_single
            assign quo_next = qbits;
        end
    endgenerate

    assign push          = cmd.div_step && st.digit_done;
    assign st.digit_done = (chunk_reg == CHW'(NCHUNK - 1));
    assign st.quo_zero   = (quo_next == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg   <= QW'(item.value[IN_BITS-1:0]);
            rem_reg   <= '0;
            chunk_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            if (st.digit_done)
            begin
                rem_reg   <= '0;
                chunk_reg <= '0;
            end
            else
            begin
                rem_reg   <= rem_next;
                chunk_reg <= chunk_reg + CHW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (item.radix < itpt_pkg::RADIX_MIN)
                radix_reg <= itpt_pkg::RADIX_MIN;
            else if (item.radix > itpt_pkg::RADIX_MAX)
                radix_reg <= itpt_pkg::RADIX_MAX;
            else
                radix_reg <= item.radix;
            if (item.min_width > itpt_pkg::MINW_W'(MAX_WIDTH))
                wid_reg <= CW'(MAX_WIDTH);
            else
                wid_reg <= CW'(item.min_width);
            left_reg <= item.left_align;
            zpad_reg <= item.zero_pad;
            up_reg   <= item.upper_case;
        end
    end

    // choose what the next character is
    always_comb
    begin
        if (left_reg)
            kind = sign_reg ? K_SIGN : ((ndig_reg != '0) ? K_DIG : K_PAD);
        else if (zpad_reg)
            kind = sign_reg ? K_SIGN : ((pad_reg != '0) ? K_PAD : K_DIG);
        else
            kind = (pad_reg != '0) ? K_PAD : (sign_reg ? K_SIGN : K_DIG);
    end

    always_comb
    begin
        case (kind)
            K_SIGN:  char_next = itpt_pkg::CH_MINUS;
            K_PAD:   char_next = (zpad_reg && !left_reg) ? itpt_pkg::CH_ZERO
                                                         : itpt_pkg::CH_SPACE;
            K_DIG:   char_next = itpt_pkg::digit_char(dig_reg[0], up_reg);
            default: char_next = itpt_pkg::CH_SPACE;
        endcase
    end

    assign len      = CW'(ndig_reg) + CW'(sign_reg);
    assign pad_full = (wid_reg > len) ? (wid_reg - len) : '0;
    assign out_load = cmd.emit && (run_reg != '0) && (!out_valid_reg || out_ready);
    assign st.final_char = out_load && (run_reg == CW'(1));

    // digit stack: push at entry zero, pop toward entry zero
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            dig_reg[0] <= rem_next;
            for (int i = 1; i < DEPTH; i++)
                dig_reg[i] <= dig_reg[i-1];
        end
        else if (out_load && kind == K_DIG)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
                dig_reg[i] <= dig_reg[i+1];
            dig_reg[DEPTH-1] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndig_reg <= '0;
            sign_reg <= 1'b0;
            pad_reg  <= '0;
            run_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                ndig_reg <= '0;
                sign_reg <= item.negative;
            end
            else if (push)
            begin
                ndig_reg <= ndig_reg + DW'(1);
            end
            else if (cmd.prep)
            begin
                pad_reg <= PW'(pad_full);
                run_reg <= len + pad_full;
            end
            else if (out_load)
            begin
                run_reg <= run_reg - CW'(1);
                case (kind)
                    K_SIGN:  sign_reg <= 1'b0;
                    K_PAD:   pad_reg  <= pad_reg - PW'(1);
                    K_DIG:   ndig_reg <= ndig_reg - DW'(1);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg <= char_next;
            out_last_reg <= (run_reg == CW'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

@@ rtl/integer_to_padded_text_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_padded_text_top: printf-style integer to padded ASCII text
// Converts a magnitude in radix 2..16 with sign, width and alignment options.
// ----------------------------------------------------------------------------
// Sequence: after acceptance the radix divider extracts the digits, retiring 8
//   dividend bits per cycle, then the sizing state S_PREP and the output register
//   load lead to the first valid character.
// Throughput: one character per cycle while the output channel is not stalled;
//   a new item is accepted only after the last character of the run is loaded.
// Reset: sequencer returns to idle and the output channel is emptied.
module integer_to_padded_text_top #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    itpt_in_if.sink    item,
    itpt_out_if.source text
);

    itpt_pkg::cmd_t    cmd;
    itpt_pkg::status_t st;
    itpt_pkg::in_item_t in_item;

    assign in_item.value      = item.value;
    assign in_item.radix      = item.radix;
    assign in_item.negative   = item.negative;
    assign in_item.min_width  = item.min_width;
    assign in_item.left_align = item.left_align;
    assign in_item.zero_pad   = item.zero_pad;
    assign in_item.upper_case = item.upper_case;

    itpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    itpt_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .item      (in_item),
        .out_ready (text.ready),
        .out_valid (text.valid),
        .out_char  (text.out_char),
        .out_last  (text.last)
    );

    // accepting a transaction leaves idle at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("input still ready after accepting a transaction");

    // the final character returns the sequencer to idle
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        st.final_char |=> item.ready)
        else $error("not ready after the final character");

    // output only fills during the emission phase
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(text.valid) |-> $past(cmd.emit))
        else $error("output valid outside emission");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for integer_to_padded_text_top
// Sends number-formatting requests and checks each returned character and its
// last flag against a local model of the formatter. The block is stressed with
// random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W      = itpt_pkg::VALUE_W;
    localparam int RADIX_W      = itpt_pkg::RADIX_W;
    localparam int MINW_W       = itpt_pkg::MINW_W;
    localparam int CHAR_W       = itpt_pkg::CHAR_W;
    localparam int DIGIT_W      = itpt_pkg::DIGIT_W;

    localparam int MAX_WIDTH    = 32;
    localparam int RANDOM_ITEMS = 480;
    localparam int IDLE_PCT     = 19;
    localparam int QUIET_FIRST  = 200;
    localparam int QUIET_LAST   = 300;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n;

    itpt_in_if  item_ch ();
    itpt_out_if text_ch ();

    integer_to_padded_text_top #(
        .VALUE_BITS (32),
        .MAX_WIDTH  (MAX_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .text  (text_ch)
    );

    itpt_pkg::in_item_t pending_items[$];
    text_char_t         expected_text[$];
    int                 items_taken = 0;
    int                 mismatches  = 0;
    logic               item_taken  = 1'b0;
    logic               hold_done   = 1'b0;
    int                 hold_left   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Build the exact character run for one request
    task automatic format_number(input itpt_pkg::in_item_t it);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] base;
        logic [DIGIT_W-1:0] d;
        logic [CHAR_W-1:0]  digits[$];
        logic [CHAR_W-1:0]  run[$];
        int                 width;
        int                 ntext;
        int                 npad;
        mag  = it.value;
        base = VALUE_W'(it.radix);
        if (it.radix < itpt_pkg::RADIX_MIN)
            base = VALUE_W'(itpt_pkg::RADIX_MIN);
        else if (it.radix > itpt_pkg::RADIX_MAX)
            base = VALUE_W'(itpt_pkg::RADIX_MAX);
        width = int'(it.min_width);
        if (width > MAX_WIDTH)
            width = MAX_WIDTH;
        do
        begin
            d = DIGIT_W'(mag % base);
            if (d < itpt_pkg::DEC_TEN)
                digits.push_front(itpt_pkg::CH_ZERO + CHAR_W'(d));
            else
                digits.push_front((it.upper_case ? itpt_pkg::CH_UPPER_A
                                                 : itpt_pkg::CH_LOWER_A)
                                  + CHAR_W'(d - itpt_pkg::DEC_TEN));
            mag = mag / base;
        end
        while (mag != 0);
        ntext = digits.size() + (it.negative ? 1 : 0);
        npad  = (width > ntext) ? width - ntext : 0;
        if (it.left_align)
        begin
            if (it.negative)
                run.push_back(itpt_pkg::CH_MINUS);
            run = {run, digits};
            repeat (npad) run.push_back(itpt_pkg::CH_SPACE);
        end
        else if (it.zero_pad)
        begin
            // sign goes ahead of the zeros
            if (it.negative)
                run.push_back(itpt_pkg::CH_MINUS);
            repeat (npad) run.push_back(itpt_pkg::CH_ZERO);
            run = {run, digits};
        end
        else
        begin
            repeat (npad) run.push_back(itpt_pkg::CH_SPACE);
            if (it.negative)
                run.push_back(itpt_pkg::CH_MINUS);
            run = {run, digits};
        end
        foreach (run[i])
            expected_text.push_back('{ch: run[i], last: (i == run.size() - 1)});
    endtask

    task automatic queue_item(input logic [VALUE_W-1:0] value,
                              input logic [RADIX_W-1:0] radix,
                              input logic               negative,
                              input logic [MINW_W-1:0]  min_width,
                              input logic               left_align,
                              input logic               zero_pad,
                              input logic               upper_case);
        itpt_pkg::in_item_t it;
        it.value      = value;
        it.radix      = radix;
        it.negative   = negative;
        it.min_width  = min_width;
        it.left_align = left_align;
        it.zero_pad   = zero_pad;
        it.upper_case = upper_case;
        pending_items.push_back(it);
    endtask

    // Driver: present the next request at the falling edge, hold it until taken
    always @(negedge clk)
    begin : drive_items
        itpt_pkg::in_item_t nxt;
        logic               quiet;
        quiet = (items_taken >= QUIET_FIRST) && (items_taken < QUIET_LAST);
        if (!rst_n)
        begin
            item_ch.valid      <= 1'b0;
            item_ch.value      <= '0;
            item_ch.radix      <= itpt_pkg::RADIX_MIN;
            item_ch.negative   <= 1'b0;
            item_ch.min_width  <= '0;
            item_ch.left_align <= 1'b0;
            item_ch.zero_pad   <= 1'b0;
            item_ch.upper_case <= 1'b0;
        end
        else if (!item_ch.valid || item_taken)
        begin
            if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = pending_items.pop_front();
                item_ch.valid      <= 1'b1;
                item_ch.value      <= nxt.value;
                item_ch.radix      <= nxt.radix;
                item_ch.negative   <= nxt.negative;
                item_ch.min_width  <= nxt.min_width;
                item_ch.left_align <= nxt.left_align;
                item_ch.zero_pad   <= nxt.zero_pad;
                item_ch.upper_case <= nxt.upper_case;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, one quiet stretch, one long hold-off
    always @(negedge clk)
    begin : drive_ready
        logic quiet;
        quiet = (items_taken >= QUIET_FIRST) && (items_taken < QUIET_LAST);
        if (!rst_n)
            text_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            text_ch.ready <= 1'b0;
        end
        else if (!hold_done && items_taken >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            text_ch.ready <= 1'b0;
        end
        else
            text_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: record accepted requests, check every character transaction
    always @(posedge clk)
    begin : watch_channels
        itpt_pkg::in_item_t it;
        text_char_t         want;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            it.value      = item_ch.value;
            it.radix      = item_ch.radix;
            it.negative   = item_ch.negative;
            it.min_width  = item_ch.min_width;
            it.left_align = item_ch.left_align;
            it.zero_pad   = item_ch.zero_pad;
            it.upper_case = item_ch.upper_case;
            format_number(it);
            items_taken = items_taken + 1;
        end
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("out_char: unexpected 0x%02h with nothing pending", text_ch.out_char);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_ch.out_char !== want.ch)
                begin
                    $error("out_char: expected 0x%02h, actual 0x%02h",
                           want.ch, text_ch.out_char);
                    mismatches = mismatches + 1;
                end
                if (text_ch.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, text_ch.last);
                    mismatches = mismatches + 1;
                end
            end
        end
        item_taken <= rst_n && item_ch.valid && item_ch.ready;
    end

    initial
    begin : run_test
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic [MINW_W-1:0]  width;
        int                 pick;
        rst_n <= 1'b0;

        // zero, widest runs, both letter cases, all alignments, clamped fields
        queue_item(32'd0,          5'd10, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0);
        queue_item(32'd0,          5'd10, 1'b1, 6'd5,  1'b0, 1'b1, 1'b0);
        queue_item(32'hFFFF_FFFF,  5'd2,  1'b1, 6'd32, 1'b0, 1'b0, 1'b0);
        queue_item(32'hFFFF_FFFF,  5'd2,  1'b1, 6'd32, 1'b0, 1'b1, 1'b1);
        queue_item(32'hFFFF_FFFF,  5'd2,  1'b1, 6'd63, 1'b1, 1'b1, 1'b0);
        queue_item(32'hFFFF_FFFF,  5'd16, 1'b0, 6'd0,  1'b0, 1'b0, 1'b1);
        queue_item(32'hFFFF_FFFF,  5'd16, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0);
        queue_item(32'hDEAD_BEEF,  5'd16, 1'b1, 6'd12, 1'b0, 1'b1, 1'b1);
        queue_item(32'd12345,      5'd10, 1'b1, 6'd10, 1'b0, 1'b0, 1'b0);
        queue_item(32'd12345,      5'd10, 1'b1, 6'd10, 1'b1, 1'b1, 1'b0);
        queue_item(32'd255,        5'd8,  1'b0, 6'd1,  1'b0, 1'b1, 1'b0);
        queue_item(32'h8000_0000,  5'd10, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0);
        queue_item(32'd7,          5'd0,  1'b0, 6'd4,  1'b0, 1'b1, 1'b0);
        queue_item(32'd7,          5'd1,  1'b1, 6'd0,  1'b0, 1'b0, 1'b0);
        queue_item(32'h0000_ABCD,  5'd17, 1'b0, 6'd63, 1'b1, 1'b0, 1'b1);
        queue_item(32'h0000_ABCD,  5'd31, 1'b1, 6'd33, 1'b0, 1'b1, 1'b0);
        queue_item(32'd1,          5'd3,  1'b0, 6'd33, 1'b0, 1'b1, 1'b0);
        queue_item(32'd100,        5'd10, 1'b1, 6'd3,  1'b0, 1'b1, 1'b0);
        queue_item(32'd100,        5'd10, 1'b1, 6'd4,  1'b1, 1'b0, 1'b0);
        queue_item(32'h7FFF_FFFF,  5'd11, 1'b0, 6'd0,  1'b0, 1'b0, 1'b1);
        queue_item(32'h7FFF_FFFF,  5'd13, 1'b1, 6'd16, 1'b1, 1'b0, 1'b0);
        queue_item(32'd59048,      5'd9,  1'b0, 6'd12, 1'b0, 1'b0, 1'b0);
        queue_item(32'd3124,       5'd5,  1'b1, 6'd9,  1'b0, 1'b1, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(9);
            case (pick)
                0, 1, 2, 3: value = $urandom;
                4, 5:       value = $urandom_range(255);
                6:          value = '0;
                7:          value = 32'hFFFF_FFFF >> $urandom_range(31);
                default:    value = $urandom >> $urandom_range(31);
            endcase
            radix = ($urandom_range(99) < 85) ? RADIX_W'($urandom_range(16, 2))
                                              : RADIX_W'($urandom_range(31));
            width = ($urandom_range(99) < 85) ? MINW_W'($urandom_range(MAX_WIDTH))
                                              : MINW_W'($urandom_range(63, 33));
            queue_item(value, radix, 1'($urandom_range(1)), width,
                       1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        end

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || item_ch.valid || expected_text.size() > 0)
            @(negedge clk);
        // let any stray character show up
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_text.size() != 0)
        begin
            $error("out_char: %0d expected characters never arrived", expected_text.size());
            mismatches = mismatches + 1;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
